// ===== hw/rtl/wfta_pkg.sv =====
`default_nettype none

package wfta_pkg;

    localparam int GRID_WIDTH = 16;
    localparam int GRID_BITS  = $clog2(GRID_WIDTH);
    localparam int IDX_BITS   = 2 * GRID_BITS;
    localparam int CELL_COUNT = GRID_WIDTH * GRID_WIDTH;
    localparam int FIELD_W    = 16;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    localparam int  PADDR_W      = 3;
    localparam logic REG_ANAGLYPH = 1'b0;

    localparam logic signed [27:0] BLUR_GAIN   = 28'sd320;
    localparam logic signed [27:0] DAMP_GAIN   = 28'sd819;
    localparam logic signed [21:0] HEAT_GAIN   = 22'sd51;
    localparam logic signed [17:0] HEAT_DECAY  = 18'sd307;
    localparam logic signed [15:0] HEAT_RESEED = 16'sd512;
    localparam logic signed [15:0] ONE_Q10     = 16'sd1024;

    localparam logic [7:0]  RED_BASE   = 8'd32;
    localparam logic [7:0]  GREEN_BASE = 8'd50;
    localparam logic [7:0]  BLUE_FULL  = 8'd255;
    localparam logic [7:0]  ALPHA_BASE = 8'd146;
    localparam logic [26:0] ALPHA_GAIN = 27'd50;

    localparam logic [14:0] MIX_W30 = 15'd30;
    localparam logic [14:0] MIX_W59 = 15'd59;
    localparam logic [14:0] MIX_W11 = 15'd11;
    localparam logic [14:0] MIX_W70 = 15'd70;
    localparam logic [27:0] DIV100_MUL   = 28'd5243;
    localparam int          DIV100_SHIFT = 19;

    localparam logic signed [17:0] SAT_MAX = 18'sd32767;
    localparam logic signed [17:0] SAT_MIN = -18'sd32768;

    typedef struct packed {
        logic       func;
        logic       reseed;
        logic [7:0] pixel_index;
    } t_in_req;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } t_out_rsp;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_U_ROW0,
        ST_U_ROW1,
        ST_U_ROW2,
        ST_U_SUM,
        ST_U_WRITE,
        ST_P_READ,
        ST_P_SQUARE,
        ST_P_COLOR,
        ST_P_MIX,
        ST_P_OUT
    } t_state;

    typedef enum logic [1:0] {
        ROW_UP2,
        ROW_UP1,
        ROW_HERE,
        ROW_PIXEL
    } t_row_sel;

    typedef struct packed {
        t_row_sel row_sel;
        logic     clear_wr;
        logic     acc_load;
        logic     acc_add;
        logic     cell_wr;
        logic     sq_load;
        logic     color_load;
        logic     mix_load;
        logic     out_load;
    } t_ctl;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] res;
        if (v > SAT_MAX) begin
            res = 16'sh7fff;
        end else if (v < SAT_MIN) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    function automatic logic [7:0] div100(input logic [14:0] v);
        logic [27:0] prod;
        prod = 28'(v) * DIV100_MUL;
        return 8'(prod >> DIV100_SHIFT);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/water_flow_texture_animator.sv =====
// Channel   Direction  Handshake                   Payload
// in        request    i_in_valid / o_in_ready     i_in_req  (t_in_req)
// out       result     o_out_valid / i_out_ready   o_out_rsp (t_out_rsp)
// cfg       APB write  psel penable pwrite pready  paddr pwdata prdata
//
// Update request: three reads through the field memory's single read port, then a sum and a write-back.
// Pixel request: read, square, color and mix steps, then the output register (divide by 100 in anaglyph mode).
// One request at a time; a new one is taken while a result waits in the output register.
// After reset a clearing pass over all 256 cells zeroes the damping and heat memories and the current field bank
// before the first request. A stalled result holds the pixel pipeline in its last stage.
`default_nettype none

module water_flow_texture_animator
    import wfta_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_req            i_in_req,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_rsp                o_out_rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    t_state r_state, n_state;
    t_ctl   ctl;

    t_in_req                r_req;
    logic [IDX_BITS-1:0]    r_cursor;
    logic                   r_sel;
    logic [GRID_BITS-1:0]   r_scroll;
    logic                   r_anaglyph;
    logic                   r_out_valid;
    t_out_rsp               r_out_rsp;

    logic signed [FIELD_W-1:0] m_field [2*CELL_COUNT];
    logic signed [FIELD_W-1:0] m_damp  [CELL_COUNT];
    logic signed [FIELD_W-1:0] m_heat  [CELL_COUNT];
    logic signed [FIELD_W-1:0] r_fld_rd, r_damp_rd, r_heat_rd;

    logic signed [17:0] r_acc;
    logic [20:0]        r_sq;
    logic [7:0]         r_red, r_green, r_alpha;
    logic [14:0]        r_mix_r, r_mix_g, r_mix_b;

    logic [GRID_BITS-1:0]  cur_y, cur_x, pix_y, pix_x, row_y;
    logic [IDX_BITS-1:0]   pix_idx;
    logic [IDX_BITS:0]     fld_ra, fld_wa;
    logic                  mem_we;
    logic signed [FIELD_W-1:0] fld_wd, damp_wd, heat_wd;

    logic signed [27:0] blur_sum;
    logic signed [21:0] heat_mul;
    logic signed [17:0] damp_sum, heat_sum;
    logic signed [15:0] next_val, damp_sat, damp_new, heat_new;

    logic signed [FIELD_W-1:0] clamp_v;
    logic [10:0]               clamp_u;
    logic [26:0]               alpha_mul;
    logic                      out_free;

    assign cur_y   = r_cursor[IDX_BITS-1:GRID_BITS];
    assign cur_x   = r_cursor[GRID_BITS-1:0];
    assign pix_idx = IDX_BITS'(r_req.pixel_index);
    assign pix_y   = pix_idx[IDX_BITS-1:GRID_BITS];
    assign pix_x   = pix_idx[GRID_BITS-1:0];

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:    if (r_cursor == '1) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_req.func == FUNC_READ) ? ST_P_READ : ST_U_ROW0;
                end
            end
            ST_U_ROW0:   n_state = ST_U_ROW1;
            ST_U_ROW1:   n_state = ST_U_ROW2;
            ST_U_ROW2:   n_state = ST_U_SUM;
            ST_U_SUM:    n_state = ST_U_WRITE;
            ST_U_WRITE:  n_state = ST_IDLE;
            ST_P_READ:   n_state = ST_P_SQUARE;
            ST_P_SQUARE: n_state = ST_P_COLOR;
            ST_P_COLOR:  n_state = ST_P_MIX;
            ST_P_MIX:    n_state = ST_P_OUT;
            ST_P_OUT:    if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        ctl.row_sel = ROW_HERE;
        unique case (r_state)
            ST_CLEAR:    ctl.clear_wr = 1'b1;
            ST_IDLE:     ;
            ST_U_ROW0:   ctl.row_sel = ROW_UP2;
            ST_U_ROW1: begin
                ctl.row_sel  = ROW_UP1;
                ctl.acc_load = 1'b1;
            end
            ST_U_ROW2: begin
                ctl.row_sel = ROW_HERE;
                ctl.acc_add = 1'b1;
            end
            ST_U_SUM:    ctl.acc_add = 1'b1;
            ST_U_WRITE:  ctl.cell_wr = 1'b1;
            ST_P_READ:   ctl.row_sel = ROW_PIXEL;
            ST_P_SQUARE: ctl.sq_load = 1'b1;
            ST_P_COLOR:  ctl.color_load = 1'b1;
            ST_P_MIX:    ctl.mix_load = 1'b1;
            ST_P_OUT:    ctl.out_load = out_free;
            default:     ;
        endcase
    end

    always_comb begin
        unique case (ctl.row_sel)
            ROW_UP2:   row_y = cur_y - GRID_BITS'(2);
            ROW_UP1:   row_y = cur_y - GRID_BITS'(1);
            ROW_HERE:  row_y = cur_y;
            ROW_PIXEL: row_y = pix_y - r_scroll;
            default:   row_y = cur_y;
        endcase
        fld_ra = {r_sel, row_y, (ctl.row_sel == ROW_PIXEL) ? pix_x : cur_x};
    end

    assign blur_sum = 28'(r_acc) * BLUR_GAIN + 28'(r_damp_rd) * DAMP_GAIN;
    assign next_val = sat16($signed(blur_sum[27:10]));
    assign heat_mul = 22'(r_heat_rd) * HEAT_GAIN;
    assign damp_sum = 18'(r_damp_rd) + 18'($signed(heat_mul[21:10]));
    assign damp_sat = sat16(damp_sum);
    assign damp_new = damp_sat[15] ? 16'sd0 : damp_sat;
    assign heat_sum = 18'(r_heat_rd) - HEAT_DECAY;
    assign heat_new = r_req.reseed ? HEAT_RESEED : sat16(heat_sum);

    assign mem_we  = ctl.clear_wr | ctl.cell_wr;
    assign fld_wa  = ctl.clear_wr ? {r_sel, r_cursor} : {~r_sel, r_cursor};
    assign fld_wd  = ctl.clear_wr ? '0 : next_val;
    assign damp_wd = ctl.clear_wr ? '0 : damp_new;
    assign heat_wd = ctl.clear_wr ? '0 : heat_new;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_field[fld_wa] <= fld_wd;
        end
        r_fld_rd <= m_field[fld_ra];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_damp[r_cursor] <= damp_wd;
        end
        r_damp_rd <= m_damp[r_cursor];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_heat[r_cursor] <= heat_wd;
        end
        r_heat_rd <= m_heat[r_cursor];
    end

    always_comb begin
        clamp_v = r_fld_rd;
        if (r_fld_rd < 16'sd0) begin
            clamp_v = 16'sd0;
        end else if (r_fld_rd > ONE_Q10) begin
            clamp_v = ONE_Q10;
        end
        clamp_u = clamp_v[10:0];
    end

    assign alpha_mul = 27'(r_sq) * ALPHA_GAIN;

    always_ff @(posedge i_clk) begin
        if (ctl.acc_load) begin
            r_acc <= 18'(r_fld_rd);
        end else if (ctl.acc_add) begin
            r_acc <= r_acc + 18'(r_fld_rd);
        end
        if (ctl.sq_load) begin
            r_sq <= 21'(clamp_u) * 21'(clamp_u);
        end
        if (ctl.color_load) begin
            r_red   <= RED_BASE + 8'(r_sq >> 15);
            r_green <= GREEN_BASE + 8'(r_sq >> 14);
            r_alpha <= ALPHA_BASE + 8'(alpha_mul >> 20);
        end
        if (ctl.mix_load) begin
            r_mix_r <= 15'(r_red) * MIX_W30 + 15'(r_green) * MIX_W59
                     + 15'(BLUE_FULL) * MIX_W11;
            r_mix_g <= 15'(r_red) * MIX_W30 + 15'(r_green) * MIX_W70;
            r_mix_b <= 15'(r_red) * MIX_W30 + 15'(BLUE_FULL) * MIX_W70;
        end
        if (ctl.out_load) begin
            r_out_rsp.alpha_out <= r_alpha;
            if (r_anaglyph) begin
                r_out_rsp.red_out   <= div100(r_mix_r);
                r_out_rsp.green_out <= div100(r_mix_g);
                r_out_rsp.blue_out  <= div100(r_mix_b);
            end else begin
                r_out_rsp.red_out   <= r_red;
                r_out_rsp.green_out <= r_green;
                r_out_rsp.blue_out  <= BLUE_FULL;
            end
        end
        if (r_state == ST_IDLE && i_in_valid) begin
            r_req <= i_in_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cursor    <= '0;
            r_sel       <= 1'b0;
            r_scroll    <= '0;
            r_anaglyph  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                r_cursor <= r_cursor + IDX_BITS'(1);
            end
            if (ctl.cell_wr && r_cursor == '1) begin
                r_sel    <= ~r_sel;
                r_scroll <= r_scroll + GRID_BITS'(1);
            end
            if (psel && penable && pwrite && paddr[2] == REG_ANAGLYPH) begin
                r_anaglyph <= pwdata[0];
            end
            if (ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_ANAGLYPH) ? {31'd0, r_anaglyph} : 32'd0;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
    import wfta_pkg::*;

    localparam int ITEMS_PER_PHASE = 225;
    localparam int PHASES          = 8;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLDOFF_CYCLES  = 400;
    localparam int READ_PCT        = 20;
    localparam int SPARE_REG_INDEX = 1;

    localparam logic [PADDR_W-1:0] ANAGLYPH_ADDR = PADDR_W'(4 * int'(REG_ANAGLYPH));
    localparam logic [PADDR_W-1:0] SPARE_ADDR    = PADDR_W'(4 * SPARE_REG_INDEX);

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in_req             i_in_req;
    logic                o_out_valid;
    logic                i_out_ready;
    t_out_rsp            o_out_rsp;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holdoff_seq    = 0;

    water_flow_texture_animator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    class pixel_scoreboard;
        logic signed [15:0] cur_field  [CELL_COUNT];
        logic signed [15:0] next_field [CELL_COUNT];
        logic signed [15:0] damp_field [CELL_COUNT];
        logic signed [15:0] heat_field [CELL_COUNT];
        logic [3:0]         scroll;
        logic [7:0]         cursor;
        logic               anaglyph;
        t_out_rsp           expected_pixels[$];
        int                 errors;
        int                 updates;
        int                 reads;
        int                 frames;
        int                 checked;
        int                 anaglyph_reads;

        function new();
            for (int i = 0; i < CELL_COUNT; i++) begin
                cur_field[i]  = '0;
                next_field[i] = '0;
                damp_field[i] = '0;
                heat_field[i] = '0;
            end
            scroll = '0;
            cursor = '0;
            anaglyph = 1'b0;
            errors = 0;
            updates = 0;
            reads = 0;
            frames = 0;
            checked = 0;
            anaglyph_reads = 0;
        endfunction

        function logic signed [15:0] clamp_q10(longint v);
            if (v > 32767) begin
                return 16'sh7fff;
            end
            if (v < -32768) begin
                return 16'sh8000;
            end
            return 16'(v);
        endfunction

        function void write_reg(logic [PADDR_W-1:0] addr, logic [31:0] data);
            if (addr == ANAGLYPH_ADDR) begin
                anaglyph = data[0];
            end
        endfunction

        function void advance_cell(logic reseed);
            int                 idx;
            int                 x;
            int                 y;
            longint             sum;
            logic signed [15:0] d;
            idx = int'(cursor);
            x = idx % GRID_WIDTH;
            y = idx / GRID_WIDTH;
            sum = 0;
            for (int k = 0; k < 3; k++) begin
                sum += cur_field[((y + GRID_WIDTH - 2 + k) % GRID_WIDTH) * GRID_WIDTH + x];
            end
            // arithmetic shift gives the floor of a division by 1024
            next_field[idx] = clamp_q10((sum * 320 + longint'(damp_field[idx]) * 819) >>> 10);
            d = clamp_q10(longint'(damp_field[idx]) + ((longint'(heat_field[idx]) * 51) >>> 10));
            damp_field[idx] = (d < 0) ? 16'sd0 : d;
            heat_field[idx] = clamp_q10(longint'(heat_field[idx]) - 307);
            if (reseed) begin
                heat_field[idx] = 16'sd512;
            end
            updates++;
            if (idx == CELL_COUNT - 1) begin
                for (int i = 0; i < CELL_COUNT; i++) begin
                    cur_field[i] = next_field[i];
                end
                scroll++;
                frames++;
            end
            cursor++;
        endfunction

        function void predict_pixel(logic [7:0] pix);
            int          x;
            int          y;
            int          v;
            int unsigned q;
            int unsigned r;
            int unsigned g;
            int unsigned b;
            int unsigned a;
            int unsigned mr;
            t_out_rsp    want;
            x = int'(pix) % GRID_WIDTH;
            y = int'(pix) / GRID_WIDTH;
            v = cur_field[((y + GRID_WIDTH - int'(scroll)) % GRID_WIDTH) * GRID_WIDTH + x];
            if (v > 1024) begin
                v = 1024;
            end
            if (v < 0) begin
                v = 0;
            end
            q = v * v;
            r = 32 + (q >> 15);
            g = 50 + (q >> 14);
            b = 255;
            a = 146 + int'((longint'(q) * 50) >> 20);
            if (anaglyph) begin
                mr = (r * 30 + g * 59 + b * 11) / 100;
                g = (r * 30 + g * 70) / 100;
                b = (r * 30 + b * 70) / 100;
                r = mr;
                anaglyph_reads++;
            end
            want.red_out   = 8'(r);
            want.green_out = 8'(g);
            want.blue_out  = 8'(b);
            want.alpha_out = 8'(a);
            expected_pixels.push_back(want);
            reads++;
        endfunction

        function void note_request(t_in_req req);
            if (req.func == FUNC_READ) begin
                predict_pixel(req.pixel_index);
            end else begin
                advance_cell(req.reseed);
            end
        endfunction

        function void check_pixel(t_out_rsp got);
            t_out_rsp want;
            string    names[4];
            names = '{"red_out", "green_out", "blue_out", "alpha_out"};
            if (expected_pixels.size() == 0) begin
                $error("pixel result %h with no read request pending", got);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            checked++;
            for (int i = 0; i < 4; i++) begin
                if (got[31 - 8 * i -: 8] !== want[31 - 8 * i -: 8]) begin
                    $error("%s: expected %0d, got %0d", names[i],
                           want[31 - 8 * i -: 8], got[31 - 8 * i -: 8]);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    pixel_scoreboard pixels = new();

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : result_sink
        int stall_left;
        int seen_seq;
        stall_left = 0;
        seen_seq = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                pixels.check_pixel(o_out_rsp);
            end
            if (holdoff_seq != seen_seq) begin
                seen_seq = holdoff_seq;
                stall_left = HOLDOFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic t_in_req make_request(logic func, logic reseed, logic [7:0] pix);
        t_in_req req;
        req.func = func;
        req.reseed = reseed;
        req.pixel_index = pix;
        return req;
    endfunction

    task automatic offer_request(input t_in_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= req;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        pixels.note_request(req);
    endtask

    task automatic wait_pixels_drained();
        i_in_valid <= 1'b0;
        while (pixels.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        pixels.write_reg(addr, data);
    endtask

    initial begin
        int          mode;
        int          reseed_pct;
        logic [31:0] data;
        t_in_req     req;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_req <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reseed on a read and pixel index on an update are both don't-care
        offer_request(make_request(FUNC_READ, 1'b1, 8'd0));
        offer_request(make_request(FUNC_READ, 1'b0, 8'd255));
        offer_request(make_request(FUNC_UPDATE, 1'b0, 8'd255));
        offer_request(make_request(FUNC_UPDATE, 1'b1, 8'd0));
        offer_request(make_request(FUNC_UPDATE, 1'b1, 8'hAA));
        offer_request(make_request(FUNC_READ, 1'b0, 8'h80));
        offer_request(make_request(FUNC_READ, 1'b1, 8'h7F));
        wait_pixels_drained();
        apb_write(ANAGLYPH_ADDR, 32'hFFFF_FFFF);
        offer_request(make_request(FUNC_READ, 1'b0, 8'd0));
        offer_request(make_request(FUNC_READ, 1'b1, 8'd255));
        offer_request(make_request(FUNC_READ, 1'b0, 8'h55));
        wait_pixels_drained();
        // unmapped register: anaglyph must stay on
        apb_write(SPARE_ADDR, 32'h0);
        offer_request(make_request(FUNC_READ, 1'b0, 8'h10));
        wait_pixels_drained();
        apb_write(ANAGLYPH_ADDR, 32'h0);

        for (int phase = 0; phase < PHASES; phase++) begin
            mode = phase % 4;
            send_idle_pct  = (mode == 1) ? 57 : (mode == 3) ? 33 : 0;
            recv_stall_pct = (mode == 2) ? 57 : (mode == 3) ? 33 : 0;
            reseed_pct = (phase == 5) ? 10 : 85;
            wait_pixels_drained();
            data = $urandom;
            data[0] = 1'((phase / 4) ^ (phase % 2));
            apb_write(ANAGLYPH_ADDR, data);
            if (phase == 3) begin
                apb_write(SPARE_ADDR, $urandom);
            end
            if (phase == 0) begin
                holdoff_seq++;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 2 && n == ITEMS_PER_PHASE / 2) begin
                    wait_pixels_drained();
                end
                req.func = ($urandom_range(99) < READ_PCT) ? FUNC_READ : FUNC_UPDATE;
                req.reseed = ($urandom_range(99) < reseed_pct);
                req.pixel_index = 8'($urandom_range(255));
                offer_request(req);
            end
        end

        wait_pixels_drained();
        $display("Ran %0d cell updates over %0d full frames and %0d pixel reads",
                 pixels.updates, pixels.frames, pixels.reads);
        $display("Checked %0d pixels, %0d with anaglyph mixing, under four idle patterns",
                 pixels.checked, pixels.anaglyph_reads);
        if (pixels.errors == 0 && pixels.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
